// ===== rtl/life_grid_generation_step_core_macros.svh =====
// Assertion macros for the life grid step core checker.
// Used by lgs_checker.sv; expects clk and rst_n in the including scope.
`ifndef LIFE_GRID_GENERATION_STEP_CORE_MACROS_SVH
`define LIFE_GRID_GENERATION_STEP_CORE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define LGS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset.
`define LGS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lgs_pkg.sv =====
// Shared types and constants for the life grid step core.
// No dependencies; used by the interfaces, the core, the row rule, the checker and the testbench.
`timescale 1ns / 1ps

package lgs_pkg;

  localparam int GRID_COLS_DEF = 32;
  localparam int GRID_ROWS_DEF = 32;

  localparam int OP_W    = 2;
  localparam int POS_W   = 5;
  localparam int DIM_W   = 6;
  localparam int ROW_W   = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [DIM_W-1:0] DIM_MIN   = 6'd3;
  localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [OP_W-1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_STEP  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EDIT,
    ST_FILL,
    ST_RUN
  } state_t;

endpackage

// ===== rtl/lgs_ifs.sv =====
// Valid/ready channel interfaces for edit/step items and row results.
// Depends on lgs_pkg for field widths.
`timescale 1ns / 1ps

interface lgs_in_if;
  logic                       valid;
  logic                       ready;
  logic [lgs_pkg::OP_W-1:0]   operation;
  logic [lgs_pkg::POS_W-1:0]  col;
  logic [lgs_pkg::POS_W-1:0]  row;

  modport source (output valid, operation, col, row, input ready);
  modport sink   (input valid, operation, col, row, output ready);
endinterface

interface lgs_out_if;
  logic                       valid;
  logic                       ready;
  logic [lgs_pkg::POS_W-1:0]  row_index;
  logic [lgs_pkg::ROW_W-1:0]  row_bits;
  logic                       last;

  modport source (output valid, row_index, row_bits, last, input ready);
  modport sink   (input valid, row_index, row_bits, last, output ready);
endinterface

// ===== rtl/life_grid_generation_step_core.sv =====
// Life grid step core: edit and generation-step items against a row store.
// Depends on lgs_pkg, lgs_ifs, lgs_grid_mem and lgs_row_rule.
//
//   port    dir  content
//   in_ch   in   operation, col, row
//   out_ch  out  row_index, row_bits, last
//   cfg_*   in   active_width (index 0), active_height (index 1)
//
// Edit: accept with row read, then modify/write/emit; a dropped edit ends at the accept.
// Step: accept, window fill, then one row per cycle, paced by the
// single read port of the row store; each row waits while the result is stalled.
// Reset clears the grid at once through per-row valid bits.
// A new item is taken once the last result is registered.
`timescale 1ns / 1ps

module life_grid_generation_step_core #(
  parameter int GRID_COLS = lgs_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = lgs_pkg::GRID_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lgs_in_if.sink                          in_ch,
  lgs_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lgs_pkg::DIM_W-1:0]       cfg_wdata
);

  localparam int CW  = (GRID_COLS < 32) ? GRID_COLS : 32;
  localparam int RD  = (GRID_ROWS < 32) ? GRID_ROWS : 32;
  localparam int CWW = $clog2(CW);
  localparam int AW  = $clog2(RD);
  localparam int DW  = lgs_pkg::DIM_W;

  lgs_pkg::state_t   state_r, state_nxt;
  logic [DW-1:0]     width_r, height_r;
  logic [DW-1:0]     w_eff, h_eff;
  logic [CW-1:0]     act_m, inner_m, rule_m;
  logic [AW-1:0]     r_r, r_nxt;
  logic [CWW-1:0]    col_r, col_nxt;
  logic              set_r, set_nxt;
  logic [CW-1:0]     up_r, up_nxt, mid_r, mid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [lgs_pkg::POS_W-1:0] out_row_r, out_row_nxt;
  logic [lgs_pkg::ROW_W-1:0] out_bits_r, out_bits_nxt;
  logic              out_last_r, out_last_nxt;
  logic              slot_free, load, in_rdy;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [CW-1:0]     rd_data, wr_data, nrow, edit_row, bit_m;
  logic [DW-1:0]     r_ext;
  logic              row_inner, r_is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lgs_pkg::DIM_RESET;
      height_r <= lgs_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (lgs_pkg::cfg_idx_t'(cfg_index))
        lgs_pkg::CFG_WIDTH:  width_r  <= cfg_wdata;
        lgs_pkg::CFG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r < lgs_pkg::DIM_MIN) begin
      w_eff = lgs_pkg::DIM_MIN;
    end else if (width_r > DW'(CW)) begin
      w_eff = DW'(CW);
    end else begin
      w_eff = width_r;
    end
    if (height_r < lgs_pkg::DIM_MIN) begin
      h_eff = lgs_pkg::DIM_MIN;
    end else if (height_r > DW'(RD)) begin
      h_eff = DW'(RD);
    end else begin
      h_eff = height_r;
    end
    for (int c = 0; c < CW; c++) begin
      act_m[c]   = DW'(c) < w_eff;
      inner_m[c] = (c >= 1) && (DW'(c + 1) < w_eff);
    end
  end

  assign r_ext     = DW'(r_r);
  assign r_is_last = (r_ext + DW'(1)) == h_eff;
  assign row_inner = (r_r != '0) && !r_is_last;
  assign rule_m    = inner_m & {CW{row_inner}};
  assign bit_m     = CW'(1) << col_r;
  assign edit_row  = set_r ? (rd_data | bit_m) : (rd_data & ~bit_m);
  assign slot_free = !out_valid_r || out_ch.ready;

  lgs_grid_mem #(
    .DEPTH (RD),
    .WIDTH (CW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lgs_row_rule #(
    .WIDTH (CW)
  ) u_rule (
    .up    (up_r),
    .mid   (mid_r),
    .dn    (rd_data),
    .inner (rule_m),
    .nxt   (nrow)
  );

  always_comb begin
    state_nxt    = state_r;
    in_rdy       = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = r_r;
    wr_data      = (mid_r & ~act_m) | nrow;
    load         = 1'b0;
    out_row_nxt  = out_row_r;
    out_bits_nxt = out_bits_r;
    out_last_nxt = out_last_r;
    r_nxt        = r_r;
    col_nxt      = col_r;
    set_nxt      = set_r;
    up_nxt       = up_r;
    mid_nxt      = mid_r;
    unique case (state_r)
      lgs_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_ch.valid) begin
          unique case (lgs_pkg::op_t'(in_ch.operation)) inside
            lgs_pkg::OP_SET, lgs_pkg::OP_CLEAR: begin
              if ((DW'(in_ch.col) < w_eff) && (DW'(in_ch.row) < h_eff)) begin
                rd_en     = 1'b1;
                rd_addr   = in_ch.row[AW-1:0];
                r_nxt     = in_ch.row[AW-1:0];
                col_nxt   = in_ch.col[CWW-1:0];
                set_nxt   = lgs_pkg::op_t'(in_ch.operation) == lgs_pkg::OP_SET;
                state_nxt = lgs_pkg::ST_EDIT;
              end
            end
            lgs_pkg::OP_STEP: begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = lgs_pkg::ST_FILL;
            end
            default: ;
          endcase
        end
      end
      lgs_pkg::ST_EDIT: begin
        if (slot_free) begin
          wr_en        = 1'b1;
          wr_data      = edit_row;
          load         = 1'b1;
          out_row_nxt  = lgs_pkg::POS_W'(r_r);
          out_bits_nxt = lgs_pkg::ROW_W'(edit_row & act_m);
          out_last_nxt = 1'b1;
          state_nxt    = lgs_pkg::ST_IDLE;
        end
      end
      lgs_pkg::ST_FILL: begin
        up_nxt    = '0;
        mid_nxt   = rd_data;
        r_nxt     = '0;
        rd_en     = 1'b1;
        rd_addr   = AW'(1);
        state_nxt = lgs_pkg::ST_RUN;
      end
      lgs_pkg::ST_RUN: begin
        if (slot_free) begin
          wr_en        = 1'b1;
          load         = 1'b1;
          out_row_nxt  = lgs_pkg::POS_W'(r_r);
          out_bits_nxt = lgs_pkg::ROW_W'(nrow);
          out_last_nxt = r_is_last;
          up_nxt       = mid_r;
          mid_nxt      = rd_data;
          r_nxt        = r_r + AW'(1);
          if ((r_ext + DW'(2)) < h_eff) begin
            rd_en   = 1'b1;
            rd_addr = AW'(r_ext + DW'(2));
          end
          if (r_is_last) begin
            state_nxt = lgs_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = lgs_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lgs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r        <= r_nxt;
    col_r      <= col_nxt;
    set_r      <= set_nxt;
    up_r       <= up_nxt;
    mid_r      <= mid_nxt;
    out_row_r  <= out_row_nxt;
    out_bits_r <= out_bits_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready      = in_rdy;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_index = out_row_r;
  assign out_ch.row_bits  = out_bits_r;
  assign out_ch.last      = out_last_r;

endmodule

// ===== rtl/lgs_grid_mem.sv =====
// Grid row store: one write and one registered read port, per-row valid
// bits so that reset clears the grid at once. Depends on nothing.
`timescale 1ns / 1ps

module lgs_grid_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_q_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ===== rtl/lgs_row_rule.sv =====
// B3/S23 rule across one row, from the old rows above, at and below.
// Depends on lgs_pkg for the birth and survival counts.
`timescale 1ns / 1ps

module lgs_row_rule #(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0] up,
  input  logic [WIDTH-1:0] mid,
  input  logic [WIDTH-1:0] dn,
  input  logic [WIDTH-1:0] inner,
  output logic [WIDTH-1:0] nxt
);

  logic [WIDTH-1:0] upl, upr, midl, midr, dnl, dnr;
  logic [3:0]       cnt [WIDTH];

  assign upl  = up  << 1;
  assign upr  = up  >> 1;
  assign midl = mid << 1;
  assign midr = mid >> 1;
  assign dnl  = dn  << 1;
  assign dnr  = dn  >> 1;

  always_comb begin
    for (int c = 0; c < WIDTH; c++) begin
      cnt[c] = 4'(upl[c]) + 4'(up[c]) + 4'(upr[c]) + 4'(midl[c]) + 4'(midr[c])
             + 4'(dnl[c]) + 4'(dn[c]) + 4'(dnr[c]);
      nxt[c] = inner[c] && ((cnt[c] == lgs_pkg::BIRTH_COUNT) ||
               (mid[c] && (cnt[c] == lgs_pkg::SURVIVE_COUNT)));
    end
  end

endmodule

// ===== rtl/lgs_checker.sv =====
// Port-level checks for the life grid step core, bound to the top level.
// Depends on lgs_pkg and life_grid_generation_step_core_macros.svh.
`timescale 1ns / 1ps
`include "life_grid_generation_step_core_macros.svh"

module lgs_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [lgs_pkg::OP_W-1:0]        in_operation,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [lgs_pkg::POS_W-1:0]       out_row_index,
  input  logic [lgs_pkg::ROW_W-1:0]       out_row_bits,
  input  logic                            out_last
);

  // stalled result holds
  `LGS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_row_bits) && $stable(out_row_index) && $stable(out_last), "stalled result changed")

  // a step keeps the input closed for at least the fill cycle
  `LGS_ASSERT_NXT(a_step_busy, in_valid && in_ready && (in_operation == lgs_pkg::OP_STEP), !in_ready, "item taken during step fill")

  // while a step is part way through its rows no new item is taken
  `LGS_ASSERT_NOW(a_sweep_busy, out_valid && !out_last, !in_ready, "item taken mid sweep")

  // rows of a step go out in order
  `LGS_ASSERT_NXT(a_row_order, out_valid && out_ready && !out_last, !out_valid || (out_row_index == $past(out_row_index) + 5'd1), "step rows out of order")

endmodule

bind life_grid_generation_step_core lgs_checker u_lgs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_operation  (in_ch.operation),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_row_index (out_ch.row_index),
  .out_row_bits  (out_ch.row_bits),
  .out_last      (out_ch.last)
);

// ===== test/tb_life_grid_generation_step_core.sv =====
`timescale 1ns / 1ps
// Testbench for life_grid_generation_step_core: edit and generation-step items are
// checked row by row against a behavioural B3/S23 model of the cell grid.
// Depends on lgs_pkg, lgs_ifs and the core RTL.

module tb_life_grid_generation_step_core;

  localparam int COL_LIMIT = (lgs_pkg::GRID_COLS_DEF < 32) ? lgs_pkg::GRID_COLS_DEF : 32;
  localparam int ROW_LIMIT = (lgs_pkg::GRID_ROWS_DEF < 32) ? lgs_pkg::GRID_ROWS_DEF : 32;
  localparam logic [lgs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [lgs_pkg::POS_W-1:0] row_index;
    logic [lgs_pkg::ROW_W-1:0] row_bits;
    logic                      last;
  } row_result_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          cfg_we;
  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lgs_pkg::DIM_W-1:0]     cfg_wdata;

  lgs_in_if  in_ch ();
  lgs_out_if out_ch ();

  life_grid_generation_step_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [lgs_pkg::ROW_W-1:0] model_grid [32];
  logic [lgs_pkg::DIM_W-1:0] model_width;
  logic [lgs_pkg::DIM_W-1:0] model_height;
  row_result_t               expected_rows [$];
  row_result_t               head_row;
  int                        errors = 0;
  int                        sent_items = 0;
  int                        in_idle_pct = 0;
  int                        out_idle_pct = 0;
  int                        stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_dim(logic [lgs_pkg::DIM_W-1:0] v, int lim);
    if (v < lgs_pkg::DIM_MIN) return int'(lgs_pkg::DIM_MIN);
    if (v > lim) return lim;
    return int'(v);
  endfunction

  function automatic void queue_row(row_result_t res);
    expected_rows = {expected_rows, res};
  endfunction

  // Updates the grid model and queues the rows the item should report.
  function automatic void predict_item(logic [lgs_pkg::OP_W-1:0] op,
                                       logic [lgs_pkg::POS_W-1:0] col,
                                       logic [lgs_pkg::POS_W-1:0] row);
    logic [lgs_pkg::ROW_W-1:0] prev [32];
    logic [lgs_pkg::ROW_W-1:0] mask;
    logic [lgs_pkg::ROW_W-1:0] next_row;
    int w, h, n;
    w = eff_dim(model_width, COL_LIMIT);
    h = eff_dim(model_height, ROW_LIMIT);
    mask = '0;
    for (int c = 0; c < w; c++) mask[c] = 1'b1;
    if (op == lgs_pkg::OP_SET || op == lgs_pkg::OP_CLEAR) begin
      if (col >= w || row >= h) return;
      model_grid[row][col] = (op == lgs_pkg::OP_SET);
      queue_row(row_result_t'{row, model_grid[row] & mask, 1'b1});
    end else if (op == lgs_pkg::OP_STEP) begin
      prev = model_grid;
      for (int r = 0; r < h; r++) begin
        next_row = '0;
        if (r != 0 && r != h - 1) begin
          for (int c = 1; c < w - 1; c++) begin
            n = 0;
            for (int dr = -1; dr <= 1; dr++)
              for (int dc = -1; dc <= 1; dc++)
                if (dr != 0 || dc != 0) n += int'(prev[r + dr][c + dc]);
            if (n == 3 || (prev[r][c] && n == 2)) next_row[c] = 1'b1;
          end
        end
        model_grid[r] = (prev[r] & ~mask) | next_row;
        queue_row(row_result_t'{r[lgs_pkg::POS_W-1:0], next_row, (r == h - 1)});
      end
    end
  endfunction

  task automatic send_item(logic [lgs_pkg::OP_W-1:0] op, logic [lgs_pkg::POS_W-1:0] col,
                           logic [lgs_pkg::POS_W-1:0] row);
    while ($urandom_range(99) < in_idle_pct) @(negedge clk);
    in_ch.operation = op;
    in_ch.col       = col;
    in_ch.row       = row;
    in_ch.valid     = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(op, col, row);
    sent_items++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_idle();
    wait (expected_rows.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(lgs_pkg::cfg_idx_t idx, logic [lgs_pkg::DIM_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == lgs_pkg::CFG_WIDTH) model_width = value;
    else model_height = value;
  endtask

  task automatic set_dims(logic [lgs_pkg::DIM_W-1:0] w, logic [lgs_pkg::DIM_W-1:0] h);
    write_cfg(lgs_pkg::CFG_WIDTH, w);
    write_cfg(lgs_pkg::CFG_HEIGHT, h);
  endtask

  function automatic logic [lgs_pkg::DIM_W-1:0] random_dim();
    int k;
    k = $urandom_range(99);
    if (k < 70) return lgs_pkg::DIM_W'($urandom_range(10, 3));
    if (k < 80) return lgs_pkg::DIM_RESET;
    if (k < 90) return lgs_pkg::DIM_W'($urandom_range(2));
    return lgs_pkg::DIM_W'($urandom_range(63, 33));
  endfunction

  // Receiver: ready changes on the falling edge only.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= out_idle_pct);
    end
  end

  function automatic void check_field(string name, logic [lgs_pkg::ROW_W-1:0] want,
                                      logic [lgs_pkg::ROW_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected row result: expected none, got row %0d bits %h last %b",
                 $time, out_ch.row_index, out_ch.row_bits, out_ch.last);
        errors++;
      end else begin
        head_row = expected_rows.pop_front();
        check_field("row_index", lgs_pkg::ROW_W'(head_row.row_index),
                    lgs_pkg::ROW_W'(out_ch.row_index));
        check_field("row_bits", head_row.row_bits, out_ch.row_bits);
        check_field("last", lgs_pkg::ROW_W'(head_row.last), lgs_pkg::ROW_W'(out_ch.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_life_grid_generation_step_core NOT OK");
      $finish;
    end
  end

  task automatic test_cleared_grid();
    send_item(lgs_pkg::OP_STEP, '0, '0);
  endtask

  // Corner cells sit on the ring, so the step kills them all.
  task automatic test_corner_edits();
    send_item(lgs_pkg::OP_SET, 5'd0, 5'd0);
    send_item(lgs_pkg::OP_SET, 5'd31, 5'd0);
    send_item(lgs_pkg::OP_SET, 5'd0, 5'd31);
    send_item(lgs_pkg::OP_SET, 5'd31, 5'd31);
    send_item(lgs_pkg::OP_CLEAR, 5'd31, 5'd31);
    send_item(lgs_pkg::OP_STEP, 5'd31, 5'd31);
  endtask

  task automatic test_ignored_items();
    send_item(OP_UNUSED, 5'd5, 5'd9);
    wait_idle();
    set_dims(6'd5, 6'd4);
    send_item(lgs_pkg::OP_SET, 5'd5, 5'd0);
    send_item(lgs_pkg::OP_SET, 5'd0, 5'd4);
    send_item(lgs_pkg::OP_SET, 5'd4, 5'd3);
  endtask

  // Blinker in a 5x5 window; a cell outside the window must survive untouched.
  task automatic test_blinker_in_window();
    wait_idle();
    set_dims(6'd32, 6'd32);
    send_item(lgs_pkg::OP_SET, 5'd20, 5'd20);
    wait_idle();
    set_dims(6'd5, 6'd5);
    send_item(lgs_pkg::OP_SET, 5'd1, 5'd2);
    send_item(lgs_pkg::OP_SET, 5'd2, 5'd2);
    send_item(lgs_pkg::OP_SET, 5'd3, 5'd2);
    send_item(lgs_pkg::OP_STEP, 5'd0, 5'd0);
    send_item(lgs_pkg::OP_STEP, 5'd0, 5'd0);
    wait_idle();
    set_dims(6'd32, 6'd32);
    send_item(lgs_pkg::OP_CLEAR, 5'd21, 5'd20);
  endtask

  task automatic test_dim_saturation();
    wait_idle();
    set_dims(6'd0, 6'd2);
    send_item(lgs_pkg::OP_SET, 5'd1, 5'd1);
    send_item(lgs_pkg::OP_STEP, 5'd0, 5'd0);
    wait_idle();
    set_dims(6'd63, 6'd40);
    send_item(lgs_pkg::OP_STEP, 5'd0, 5'd0);
  endtask

  task automatic test_random_traffic(int in_pct, int out_pct, int target);
    int start, w, h, k;
    logic [lgs_pkg::POS_W-1:0] c, r;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    start = sent_items;
    while (sent_items - start < target) begin
      wait_idle();
      set_dims(random_dim(), random_dim());
      w = eff_dim(model_width, COL_LIMIT);
      h = eff_dim(model_height, ROW_LIMIT);
      repeat ($urandom_range(40, 15)) begin
        k = $urandom_range(99);
        if (k < 70) begin
          c = lgs_pkg::POS_W'($urandom_range(w - 1));
          r = lgs_pkg::POS_W'($urandom_range(h - 1));
        end else begin
          c = lgs_pkg::POS_W'($urandom_range(31));
          r = lgs_pkg::POS_W'($urandom_range(31));
        end
        if (k < 55) send_item(lgs_pkg::OP_SET, c, r);
        else if (k < 70) send_item(lgs_pkg::OP_CLEAR, c, r);
        else if (k < 86) send_item(lgs_pkg::OP_STEP, c, r);
        else if (k < 93) send_item(OP_UNUSED, c, r);
        else send_item(k[0] ? lgs_pkg::OP_SET : lgs_pkg::OP_CLEAR, c, r);
      end
    end
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.operation = lgs_pkg::OP_SET;
    in_ch.col       = '0;
    in_ch.row       = '0;
    cfg_we          = 1'b0;
    cfg_index       = lgs_pkg::CFG_WIDTH;
    cfg_wdata       = '0;
    for (int r = 0; r < 32; r++) model_grid[r] = '0;
    model_width  = lgs_pkg::DIM_RESET;
    model_height = lgs_pkg::DIM_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_cleared_grid();
    test_corner_edits();
    test_ignored_items();
    test_blinker_in_window();
    test_dim_saturation();
    test_random_traffic(29, 81, 100);
    test_random_traffic(81, 29, 100);
    test_random_traffic(0, 0, 100);

    wait (expected_rows.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) $display("tb_life_grid_generation_step_core OK");
    else $display("tb_life_grid_generation_step_core NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lgs_pkg.sv
rtl/lgs_ifs.sv
rtl/lgs_grid_mem.sv
rtl/lgs_row_rule.sv
rtl/life_grid_generation_step_core.sv
rtl/lgs_checker.sv
test/tb_life_grid_generation_step_core.sv
